@@ design/cbc_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the cartridge bank controller with clock.
// Used by cbc_ctrl, cbc_datapath and the top level; depends on nothing.
package cbc_pkg;

  localparam int unsigned RomBankBits = 7;
  localparam int unsigned RomOffBits  = 14;
  localparam int unsigned RamOffBits  = 13;
  localparam int unsigned AddrBits    = 21;
  localparam int unsigned BusAddrBits = 15;
  localparam int unsigned ByteBits    = 8;
  localparam int unsigned InBits      = 3 + BusAddrBits + ByteBits;
  localparam int unsigned OutBits     = 3 + AddrBits + ByteBits;
  localparam int unsigned InTdataBits  = ((InBits + 7) / 8) * 8;
  localparam int unsigned OutTdataBits = ((OutBits + 7) / 8) * 8;

  localparam logic [7:0] OpenBus    = 8'hFF;
  localparam logic [3:0] EnableKey  = 4'hA;
  localparam logic [7:0] LatchArm   = 8'h00;
  localparam logic [7:0] LatchFire  = 8'h01;
  localparam logic [7:0] DayHiMask  = 8'hC1;
  localparam int unsigned HaltBit   = 6;
  localparam int unsigned CarryBit  = 7;

  typedef enum logic [2:0] {
    OpRomRead  = 3'd0,
    OpRomWrite = 3'd1,
    OpRamRead  = 3'd2,
    OpRamWrite = 3'd3,
    OpTick     = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    KindOpen    = 3'd0,
    KindRomRead = 3'd1,
    KindRamRead = 3'd2,
    KindRamWr   = 3'd3,
    KindClock   = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    RegionEnable  = 2'd0,
    RegionRomBank = 2'd1,
    RegionRamBank = 2'd2,
    RegionLatch   = 2'd3
  } region_e;

  typedef enum logic [3:0] {
    SelSeconds = 4'd8,
    SelMinutes = 4'd9,
    SelHours   = 4'd10,
    SelDayLow  = 4'd11,
    SelDayHigh = 4'd12
  } clk_sel_e;

  typedef enum logic [1:0] {
    CfgHasClock = 2'd0,
    CfgRomBanks = 2'd1,
    CfgRamBanks = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic exec;
  } cbc_cmd_t;

endpackage

@@ design/cbc_ctrl.sv @@
`timescale 1ns / 1ps
// Handshake sequencer of the cartridge bank controller.
// Depends on cbc_pkg; drives the datapath through cbc_cmd_t.
module cbc_ctrl import cbc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output cbc_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StResp = 2'b10
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.exec = 1'b1;
          state_d    = StResp;
        end
      end
      StResp: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ design/cbc_datapath.sv @@
`timescale 1ns / 1ps
// Bank registers, clock counters, address mapping and result register.
// Depends on cbc_pkg; sequenced by cbc_ctrl through cbc_cmd_t.
module cbc_datapath import cbc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cbc_cmd_t                cmd_i,
  input  logic [2:0]              operation_i,
  input  logic [BusAddrBits-1:0]  bus_address_i,
  input  logic [ByteBits-1:0]     write_data_i,
  input  logic                    cfg_we_i,
  input  logic [1:0]              cfg_index_i,
  input  logic [ByteBits-1:0]     cfg_data_i,
  output logic [2:0]              access_kind_o,
  output logic [AddrBits-1:0]     memory_address_o,
  output logic [ByteBits-1:0]     data_out_o
);

  logic                   has_clock_q;
  logic [7:0]             rom_count_q;
  logic [3:0]             ram_count_q;

  logic [RomBankBits-1:0] rom_sel_q, rom_sel_d;
  logic [3:0]             ram_sel_q, ram_sel_d;
  logic                   enable_q, enable_d;
  logic                   armed_q, armed_d;
  logic [5:0]             sec_q, sec_d;
  logic [5:0]             min_q, min_d;
  logic [4:0]             hour_q, hour_d;
  logic [7:0]             dayl_q, dayl_d;
  logic [7:0]             dayh_q, dayh_d;
  logic [7:0]             latch_q [5];
  logic                   do_latch;

  logic [2:0]             kind_q, kind_d;
  logic [AddrBits-1:0]    addr_q, addr_d;
  logic [ByteBits-1:0]    data_q, data_d;

  logic [RomBankBits-1:0]            rom_bank;
  logic [RomBankBits+RomOffBits-1:0] rom_pa;
  logic [RamOffBits+2:0]             ram_pa;
  logic [6:0]                        sec_sum, min_sum;
  logic [5:0]                        hour_sum;
  logic [9:0]                        day_sum;
  logic                              c_sec, c_min, c_hour;
  logic [2:0]                        latch_idx;

  always_comb begin
    rom_bank  = bus_address_i[BusAddrBits-1] ? rom_sel_q : '0;
    rom_pa    = {rom_bank, bus_address_i[RomOffBits-1:0]};
    ram_pa    = {ram_sel_q[2:0], bus_address_i[RamOffBits-1:0]};
    latch_idx = 3'(ram_sel_q - SelSeconds);

    sec_sum  = {1'b0, sec_q} + 7'd1;
    c_sec    = sec_sum >= 7'd60;
    min_sum  = {1'b0, min_q} + {6'd0, c_sec};
    c_min    = min_sum >= 7'd60;
    hour_sum = {1'b0, hour_q} + {5'd0, c_min};
    c_hour   = hour_sum >= 6'd24;
    day_sum  = {1'b0, dayh_q[0], dayl_q} + {9'd0, c_hour};
  end

  always_comb begin
    rom_sel_d = rom_sel_q;
    ram_sel_d = ram_sel_q;
    enable_d  = enable_q;
    armed_d   = armed_q;
    sec_d     = sec_q;
    min_d     = min_q;
    hour_d    = hour_q;
    dayl_d    = dayl_q;
    dayh_d    = dayh_q;
    do_latch  = 1'b0;
    kind_d    = KindOpen;
    addr_d    = '0;
    data_d    = OpenBus;

    unique case (operation_i)
      OpRomRead: begin
        if ({1'b0, rom_bank} < (RomBankBits + 1)'(rom_count_q)) begin
          kind_d = KindRomRead;
          addr_d = AddrBits'(rom_pa);
          data_d = '0;
        end
      end
      OpRomWrite: begin
        unique case (region_e'(bus_address_i[BusAddrBits-1 -: 2]))
          RegionEnable:  enable_d = write_data_i[3:0] == EnableKey;
          RegionRomBank: begin
            rom_sel_d = write_data_i[RomBankBits-1:0];
            if (write_data_i[RomBankBits-1:0] == '0) begin
              rom_sel_d = RomBankBits'(1);
            end
          end
          RegionRamBank: ram_sel_d = write_data_i[3:0];
          RegionLatch: begin
            if (has_clock_q) begin
              if (write_data_i == LatchArm) begin
                armed_d = 1'b1;
              end else if (write_data_i == LatchFire && armed_q) begin
                do_latch = 1'b1;
                armed_d  = 1'b0;
              end
            end
          end
          default: ;
        endcase
      end
      OpRamRead, OpRamWrite: begin
        if (enable_q) begin
          if (!ram_sel_q[3]) begin
            if (ram_sel_q < ram_count_q) begin
              addr_d = AddrBits'(ram_pa);
              if (operation_i == OpRamRead) begin
                kind_d = KindRamRead;
                data_d = '0;
              end else begin
                kind_d = KindRamWr;
                data_d = write_data_i;
              end
            end
          end else if (ram_sel_q <= SelDayHigh && has_clock_q) begin
            kind_d = KindClock;
            if (operation_i == OpRamRead) begin
              data_d = latch_q[latch_idx];
            end else begin
              data_d = write_data_i;
              priority case (ram_sel_q)
                SelSeconds: sec_d  = write_data_i[5:0];
                SelMinutes: min_d  = write_data_i[5:0];
                SelHours:   hour_d = write_data_i[4:0];
                SelDayLow:  dayl_d = write_data_i;
                default:    dayh_d = write_data_i & DayHiMask;
              endcase
            end
          end
        end
      end
      OpTick: begin
        if (has_clock_q && !dayh_q[HaltBit]) begin
          sec_d  = c_sec ? 6'(sec_sum - 7'd60) : sec_sum[5:0];
          min_d  = c_min ? 6'(min_sum - 7'd60) : min_sum[5:0];
          hour_d = c_hour ? 5'(hour_sum - 6'd24) : hour_sum[4:0];
          dayl_d = day_sum[7:0];
          dayh_d = {dayh_q[CarryBit] | day_sum[9], dayh_q[6:1], day_sum[8]};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      has_clock_q <= 1'b0;
      rom_count_q <= 8'd2;
      ram_count_q <= 4'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgHasClock: has_clock_q <= cfg_data_i[0];
        CfgRomBanks: rom_count_q <= cfg_data_i;
        CfgRamBanks: ram_count_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rom_sel_q <= RomBankBits'(1);
      ram_sel_q <= '0;
      enable_q  <= 1'b0;
      armed_q   <= 1'b0;
      sec_q     <= '0;
      min_q     <= '0;
      hour_q    <= '0;
      dayl_q    <= '0;
      dayh_q    <= '0;
      for (int i = 0; i < 5; i++) begin
        latch_q[i] <= '0;
      end
    end else if (cmd_i.exec) begin
      rom_sel_q <= rom_sel_d;
      ram_sel_q <= ram_sel_d;
      enable_q  <= enable_d;
      armed_q   <= armed_d;
      sec_q     <= sec_d;
      min_q     <= min_d;
      hour_q    <= hour_d;
      dayl_q    <= dayl_d;
      dayh_q    <= dayh_d;
      if (do_latch) begin
        latch_q[0] <= {2'b00, sec_q};
        latch_q[1] <= {2'b00, min_q};
        latch_q[2] <= {3'b000, hour_q};
        latch_q[3] <= dayl_q;
        latch_q[4] <= dayh_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      kind_q <= kind_d;
      addr_q <= addr_d;
      data_q <= data_d;
    end
  end

  assign access_kind_o    = kind_q;
  assign memory_address_o = addr_q;
  assign data_out_o       = data_q;

endmodule

@@ design/cartridge_bank_controller_rtc.sv @@
`timescale 1ns / 1ps
// Top level of the cartridge bank controller with real-time clock.
// Depends on cbc_pkg, cbc_ctrl and cbc_datapath.
//
//   Channel   Direction  Contents
//   s_axis    in         operation, bus_address, write_data
//   m_axis    out        access_kind, memory_address, data_out
//   cfg       in         has_clock, rom_bank_count, ram_bank_count
//
// Each transfer is executed in the accept cycle and its result is held in
// the output register until taken. A new item is accepted in the cycle
// after its result is taken at the earliest.
// Reset restores the bank selects, the clock counters and the latched copy.
// A stalled output holds the input side not ready.
module cartridge_bank_controller_rtc import cbc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // [2:0] operation, [17:3] bus_address, [25:18] write_data, rest zero.
  input  logic [InTdataBits-1:0]  s_axis_tdata,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // [2:0] access_kind, [23:3] memory_address, [31:24] data_out.
  output logic [OutTdataBits-1:0] m_axis_tdata,
  input  logic                    cfg_we_i,
  input  logic [1:0]              cfg_index_i,
  input  logic [ByteBits-1:0]     cfg_data_i
);

  cbc_cmd_t              cmd;
  logic [2:0]            kind;
  logic [AddrBits-1:0]   maddr;
  logic [ByteBits-1:0]   dout;

  cbc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  cbc_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .operation_i      (s_axis_tdata[2:0]),
    .bus_address_i    (s_axis_tdata[3 +: BusAddrBits]),
    .write_data_i     (s_axis_tdata[3+BusAddrBits +: ByteBits]),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .access_kind_o    (kind),
    .memory_address_o (maddr),
    .data_out_o       (dout)
  );

  assign m_axis_tdata = OutTdataBits'({dout, maddr, kind});

endmodule
